// File: hdl/scr_pkg.sv
// Shared constants for the segment rectangle clipper.
package scr_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 8;

    localparam int FRAME_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 16'd640;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

endpackage

// File: hdl/scr_stage.sv
// One half-plane clip stage: classify, multiply, bit-serial pipelined divide, rebuild.
module scr_stage
    import scr_pkg::*;
#(
    parameter int   COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int   FRAC_BITS   = FRAC_BITS_DEF,
    parameter logic AXIS        = AXIS_X,
    parameter logic KEEP_BELOW  = 1'b0
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic                       in_vis,
    input  logic [4*COORD_WIDTH-1:0]   in_pts,
    input  logic [FRAME_W-1:0]         frame,
    output logic                       out_valid,
    output logic                       out_vis,
    output logic [4*COORD_WIDTH-1:0]   out_pts
);

    localparam int W  = COORD_WIDTH;
    localparam int PW = 4 * W;
    localparam int BW = FRAC_BITS + FRAME_W + 1;
    localparam int E  = ((W > BW) ? W : BW) + 1;
    localparam int LAST = W + 1;

    localparam int SA = AXIS * W;
    localparam int SO = (1 - AXIS) * W;
    localparam int FA = (2 + AXIS) * W;
    localparam int FO = (3 - AXIS) * W;

    logic            valid_reg [0:LAST];
    logic            vis_reg   [0:LAST];
    logic            clip_reg  [0:LAST];
    logic            fin_reg   [0:LAST];
    logic            neg_reg   [0:LAST];
    logic [PW-1:0]   pts_reg   [0:LAST];
    logic [W-1:0]    bnd_reg   [0:LAST];
    logic [W-1:0]    den_reg   [0:LAST];
    logic [W-1:0]    magn_reg;
    logic [W-1:0]    magb_reg;
    logic [W-1:0]    rem_reg   [1:LAST];
    logic [W-1:0]    lo_reg    [1:LAST];
    logic [W-1:0]    q_reg     [1:LAST];

    logic              out_valid_reg;
    logic              out_vis_reg;
    logic [PW-1:0]     out_pts_reg;

    // Classification inputs
    logic signed [E-1:0] ua_e;
    logic signed [E-1:0] va_e;
    logic signed [E-1:0] bnd_e;
    logic signed [E-1:0] num_e;
    logic signed [W:0]   ub_x;
    logic signed [W:0]   vb_x;
    logic signed [W:0]   num;
    logic signed [W:0]   db;
    logic signed [W:0]   da;
    logic signed [W:0]   num_abs;
    logic signed [W:0]   db_abs;
    logic signed [W:0]   da_abs;
    logic                in0;
    logic                in1;
    logic [2*W-1:0]      prod;

    // Rebuild inputs
    logic [W:0]          qs;
    logic [W-1:0]        nb;
    logic [PW-1:0]       pts_next;

    always_comb
    begin
        ua_e  = E'(signed'(in_pts[SA +: W]));
        va_e  = E'(signed'(in_pts[FA +: W]));
        bnd_e = signed'({{(E-FRAME_W){1'b0}}, frame}) <<< FRAC_BITS;
        in0   = KEEP_BELOW ? (ua_e <= bnd_e) : (ua_e >= bnd_e);
        in1   = KEEP_BELOW ? (va_e <= bnd_e) : (va_e >= bnd_e);
        num_e = bnd_e - ua_e;
        num   = num_e[W:0];
        ub_x  = (W+1)'(signed'(in_pts[SO +: W]));
        vb_x  = (W+1)'(signed'(in_pts[FO +: W]));
        db    = vb_x - ub_x;
        da    = va_e[W:0] - ua_e[W:0];
        num_abs = num[W] ? -num : num;
        db_abs  = db[W]  ? -db  : db;
        da_abs  = da[W]  ? -da  : da;
    end

    // Classify the endpoints and form the magnitudes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vis_reg[0]  <= in_vis & (in0 | in1);
            clip_reg[0] <= in_vis & (in0 ^ in1);
            fin_reg[0]  <= in0;
            neg_reg[0]  <= num[W] ^ db[W] ^ da[W];
            pts_reg[0]  <= in_pts;
            bnd_reg[0]  <= bnd_e[W-1:0];
            den_reg[0]  <= da_abs[W-1:0];
            magn_reg    <= num_abs[W-1:0];
            magb_reg    <= db_abs[W-1:0];
        end
    end

    // Multiply the magnitudes
    assign prod = magn_reg * magb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[1] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[1] <= valid_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vis_reg[1]  <= vis_reg[0];
            clip_reg[1] <= clip_reg[0];
            fin_reg[1]  <= fin_reg[0];
            neg_reg[1]  <= neg_reg[0];
            pts_reg[1]  <= pts_reg[0];
            bnd_reg[1]  <= bnd_reg[0];
            den_reg[1]  <= den_reg[0];
            rem_reg[1]  <= prod[2*W-1:W];
            lo_reg[1]   <= prod[W-1:0];
            q_reg[1]    <= '0;
        end
    end

    // Divide: one quotient bit per stage, restoring
    genvar j;
    generate
        for (j = 2; j <= LAST; j++)
        begin : g_div
            logic [W:0] trial;
            logic       ge;

            always_comb
            begin
                trial = {rem_reg[j-1], lo_reg[j-1][W-1]};
                ge    = (trial >= {1'b0, den_reg[j-1]});
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[j] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[j] <= valid_reg[j-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    vis_reg[j]  <= vis_reg[j-1];
                    clip_reg[j] <= clip_reg[j-1];
                    fin_reg[j]  <= fin_reg[j-1];
                    neg_reg[j]  <= neg_reg[j-1];
                    pts_reg[j]  <= pts_reg[j-1];
                    bnd_reg[j]  <= bnd_reg[j-1];
                    den_reg[j]  <= den_reg[j-1];
                    rem_reg[j]  <= ge ? W'(trial - {1'b0, den_reg[j-1]}) : trial[W-1:0];
                    lo_reg[j]   <= {lo_reg[j-1][W-2:0], 1'b0};
                    q_reg[j]    <= {q_reg[j-1][W-2:0], ge};
                end
            end
        end
    endgenerate

    // Apply the sign, add the offset and replace the outside endpoint
    always_comb
    begin
        qs       = neg_reg[LAST] ? -{1'b0, q_reg[LAST]} : {1'b0, q_reg[LAST]};
        nb       = pts_reg[LAST][SO +: W] + qs[W-1:0];
        pts_next = pts_reg[LAST];
        if (clip_reg[LAST])
        begin
            if (fin_reg[LAST])
            begin
                pts_next[FA +: W] = bnd_reg[LAST];
                pts_next[FO +: W] = nb;
            end
            else
            begin
                pts_next[SA +: W] = bnd_reg[LAST];
                pts_next[SO +: W] = nb;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_vis_reg <= vis_reg[LAST];
            out_pts_reg <= pts_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vis   = out_vis_reg;
    assign out_pts   = out_pts_reg;

endmodule

// File: hdl/segment_rectangle_clipper_core.sv
// Top level of the segment rectangle clipper: four chained half-plane clip stages.
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  x_start y_start x_finish y_finish
//  output    out        out_valid/out_stall  visible out_x_* out_y_*
//  config    in         cfg_we               cfg_index cfg_data
//
// One request enters per cycle while in_stall is low; each clip stage holds a
// one-bit-per-stage divider.
// Reset clears all valid bits and loads frame size 640 x 480.
// The whole pipeline advances together; it holds only while a result waits
// at the output and out_stall is high, and then in_stall is raised.
module segment_rectangle_clipper_core
    import scr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [FRAME_W-1:0]            cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] x_start,
    input  logic signed [COORD_WIDTH-1:0] y_start,
    input  logic signed [COORD_WIDTH-1:0] x_finish,
    input  logic signed [COORD_WIDTH-1:0] y_finish,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          visible,
    output logic signed [COORD_WIDTH-1:0] out_x_start,
    output logic signed [COORD_WIDTH-1:0] out_y_start,
    output logic signed [COORD_WIDTH-1:0] out_x_finish,
    output logic signed [COORD_WIDTH-1:0] out_y_finish
);

    localparam int W  = COORD_WIDTH;
    localparam int PW = 4 * W;

    logic [FRAME_W-1:0] frame_width_reg;
    logic [FRAME_W-1:0] frame_height_reg;

    logic            en;
    logic            v   [0:4];
    logic            vis [0:4];
    logic [PW-1:0]   pts [0:4];

    // Write the frame size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Advance unless a finished result is held
    assign en       = !(v[4] && out_stall);
    assign in_stall = !en;

    assign v[0]   = in_valid;
    assign vis[0] = 1'b1;
    assign pts[0] = {y_finish, x_finish, y_start, x_start};

    scr_stage #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .AXIS        (AXIS_X),
        .KEEP_BELOW  (1'b0)
    ) u_left (
        .clk (clk), .rst_n (rst_n), .en (en),
        .in_valid (v[0]), .in_vis (vis[0]), .in_pts (pts[0]),
        .frame ('0),
        .out_valid (v[1]), .out_vis (vis[1]), .out_pts (pts[1])
    );

    scr_stage #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .AXIS        (AXIS_X),
        .KEEP_BELOW  (1'b1)
    ) u_right (
        .clk (clk), .rst_n (rst_n), .en (en),
        .in_valid (v[1]), .in_vis (vis[1]), .in_pts (pts[1]),
        .frame (frame_width_reg),
        .out_valid (v[2]), .out_vis (vis[2]), .out_pts (pts[2])
    );

    scr_stage #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .AXIS        (AXIS_Y),
        .KEEP_BELOW  (1'b0)
    ) u_top (
        .clk (clk), .rst_n (rst_n), .en (en),
        .in_valid (v[2]), .in_vis (vis[2]), .in_pts (pts[2]),
        .frame ('0),
        .out_valid (v[3]), .out_vis (vis[3]), .out_pts (pts[3])
    );

    scr_stage #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .AXIS        (AXIS_Y),
        .KEEP_BELOW  (1'b1)
    ) u_bottom (
        .clk (clk), .rst_n (rst_n), .en (en),
        .in_valid (v[3]), .in_vis (vis[3]), .in_pts (pts[3]),
        .frame (frame_height_reg),
        .out_valid (v[4]), .out_vis (vis[4]), .out_pts (pts[4])
    );

    // Drive the result, zeroed for an invisible segment
    assign out_valid    = v[4];
    assign visible      = vis[4];
    assign out_x_start  = vis[4] ? signed'(pts[4][0*W +: W]) : '0;
    assign out_y_start  = vis[4] ? signed'(pts[4][1*W +: W]) : '0;
    assign out_x_finish = vis[4] ? signed'(pts[4][2*W +: W]) : '0;
    assign out_y_finish = vis[4] ? signed'(pts[4][3*W +: W]) : '0;

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(pts[4]) && $stable(vis[4])))
        else $error("held result changed inside the pipeline");

    a_inner_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(v[1]) && $stable(v[2]) && $stable(v[3])))
        else $error("stage valid moved during a hold");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the segment rectangle clipper core.
`timescale 1ns / 1ps

module tb_top;
    import scr_pkg::*;

    typedef struct {
        int xs;
        int ys;
        int xf;
        int yf;
    } segment_t;

    typedef struct {
        bit                 visible;
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        logic signed [31:0] xf;
        logic signed [31:0] yf;
    } clip_result_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 160;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FRAME_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] x_start, y_start, x_finish, y_finish;
    logic out_valid;
    logic out_stall;
    logic visible;
    logic signed [31:0] out_x_start, out_y_start, out_x_finish, out_y_finish;

    segment_t     segment_q[$];
    clip_result_t clipped_q[$];
    longint       frame_w_px;
    longint       frame_h_px;
    int           mismatch_count;
    int           segs_sent;
    int           results_seen;
    int           visible_seen;
    int           idle_cycles;
    int           send_gap;
    int           recv_gap;
    bit           calm;
    bit           seg_taken;

    segment_rectangle_clipper_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .x_start(x_start), .y_start(y_start), .x_finish(x_finish), .y_finish(y_finish),
        .out_valid(out_valid), .out_stall(out_stall), .visible(visible),
        .out_x_start(out_x_start), .out_y_start(out_y_start),
        .out_x_finish(out_x_finish), .out_y_finish(out_y_finish)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Clip against one half-plane; axis 0 is x, 1 is y. Returns 0 when both ends are out.
    function automatic bit clip_plane(inout longint p[4], input int axis,
                                      input longint bound, input bit keep_below);
        int other;
        bit in0, in1;
        logic signed [127:0] num_a, num_b, den, nb;
        other = 1 - axis;
        in0 = keep_below ? (p[axis] <= bound) : (p[axis] >= bound);
        in1 = keep_below ? (p[2 + axis] <= bound) : (p[2 + axis] >= bound);
        if (in0 && in1)
            return 1'b1;
        if (!in0 && !in1)
            return 1'b0;
        num_a = bound - p[axis];
        num_b = p[2 + other] - p[other];
        den   = p[2 + axis] - p[axis];
        nb    = p[other] + (num_a * num_b) / den;
        if (in0)
        begin
            p[2 + axis]  = bound;
            p[2 + other] = longint'(nb);
        end
        else
        begin
            p[axis]  = bound;
            p[other] = longint'(nb);
        end
        return 1'b1;
    endfunction

    function automatic clip_result_t clip_segment(segment_t s);
        longint p[4];
        clip_result_t r;
        p[0] = s.xs; p[1] = s.ys; p[2] = s.xf; p[3] = s.yf;
        r.visible = clip_plane(p, 0, 0, 1'b0) && clip_plane(p, 0, frame_w_px, 1'b1)
                 && clip_plane(p, 1, 0, 1'b0) && clip_plane(p, 1, frame_h_px, 1'b1);
        r.xs = r.visible ? p[0][31:0] : '0;
        r.ys = r.visible ? p[1][31:0] : '0;
        r.xf = r.visible ? p[2][31:0] : '0;
        r.yf = r.visible ? p[3][31:0] : '0;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("ERROR at %0t: %s got %h expected %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // Pick a coordinate: mostly near the frame, sometimes on an edge or anywhere.
    function automatic int pick_coord(longint span);
        case ($urandom_range(0, 9))
            0: return int'($urandom);
            1: return 0;
            2: return int'(span);
            3: return int'(span) + int'($urandom_range(0, 2)) - 1;
            default: return int'($urandom_range(0, 3 * span)) - int'(span);
        endcase
    endfunction

    task automatic add_seg(int xs, int ys, int xf, int yf);
        segment_t s;
        s.xs = xs; s.ys = ys; s.xf = xf; s.yf = yf;
        segment_q.insert(segment_q.size(), s);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAME_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FRAME_WIDTH)
            frame_w_px = longint'(value) << 8;
        else
            frame_h_px = longint'(value) << 8;
    endtask

    // Hold until the sender and the pipeline are empty.
    task automatic wait_drained();
        while (segment_q.size() != 0 || in_valid || clipped_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_random(int count);
        repeat (count)
            add_seg(pick_coord(frame_w_px), pick_coord(frame_h_px),
                    pick_coord(frame_w_px), pick_coord(frame_h_px));
    endtask

    // Stimulus: directed segments, then random phases at several frame sizes.
    initial
    begin
        int w8, h8;
        rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; out_stall = 1'b0;
        x_start = '0; y_start = '0; x_finish = '0; y_finish = '0;
        mismatch_count = 0; segs_sent = 0; results_seen = 0; visible_seen = 0;
        idle_cycles = 0; send_gap = 0; recv_gap = 0; calm = 1'b0;
        frame_w_px = longint'(FRAME_WIDTH_RST) << 8;
        frame_h_px = longint'(FRAME_HEIGHT_RST) << 8;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        w8 = int'(frame_w_px);
        h8 = int'(frame_h_px);
        add_seg(256, 256, 1000, 2000);
        add_seg(0, 0, w8, h8);
        add_seg(w8, 0, 0, h8);
        add_seg(-10, 5, -20, 7);
        add_seg(w8 + 1, 5, w8 + 90, 700);
        add_seg(5, -1, 900, -300);
        add_seg(5, h8 + 1, 900, h8 + 300);
        add_seg(-2560, 25600, 25600, 51200);
        add_seg(25600, 51200, -2560, 25600);
        add_seg(w8 + 5000, 1000, 1000, 3000);
        add_seg(1000, 3000, w8 + 5000, 1000);
        add_seg(3000, -7777, 9000, 4000);
        add_seg(9000, 4000, 3000, h8 + 7777);
        add_seg(-1000, -1000, w8 + 1000, h8 + 1000);
        add_seg(w8 + 333, -444, -555, h8 + 666);
        add_seg(int'(32'h8000_0000), int'(32'h8000_0000),
                int'(32'h7fff_ffff), int'(32'h7fff_ffff));
        add_seg(int'(32'h7fff_ffff), int'(32'h7fff_ffff),
                int'(32'h8000_0000), int'(32'h8000_0000));
        add_seg(int'(32'h8000_0000), 100, int'(32'h7fff_ffff), 100);
        add_seg(0, 0, 0, 0);
        add_seg(-1, -1, -1, -1);
        add_seg(-300, 500, 500, -300);
        wait_drained();

        add_random(150);
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 16'd1);
        write_reg(CFG_FRAME_HEIGHT, 16'd1);
        add_random(140);
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 16'hffff);
        write_reg(CFG_FRAME_HEIGHT, 16'hffff);
        add_random(140);
        wait_drained();
        write_reg(CFG_FRAME_HEIGHT, 16'd1);
        add_random(140);
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 16'($urandom_range(1, 65535)));
        write_reg(CFG_FRAME_HEIGHT, 16'($urandom_range(1, 65535)));
        add_random(140);
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 16'd1920);
        write_reg(CFG_FRAME_HEIGHT, 16'd1080);
        calm = 1'b1;
        add_random(170);
        wait_drained();

        $display("Sent %0d segments over six frame sizes; %0d results, %0d visible.",
                 segs_sent, results_seen, visible_seen);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Record accepted requests and predict their results.
    always @(posedge clk)
    begin
        seg_taken = 1'b0;
        if (rst_n && in_valid && !in_stall)
        begin
            segment_t s;
            s.xs = x_start; s.ys = y_start; s.xf = x_finish; s.yf = y_finish;
            clipped_q.insert(clipped_q.size(), clip_segment(s));
            segs_sent++;
            seg_taken = 1'b1;
        end
    end

    // Drive the next request, with random idle bursts.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || seg_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                send_gap = $urandom_range(0, 10);
                in_valid <= 1'b0;
            end
            else if (segment_q.size() != 0)
            begin
                segment_t s;
                s = segment_q.pop_front();
                x_start  <= s.xs;
                y_start  <= s.ys;
                x_finish <= s.xf;
                y_finish <= s.yf;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall the output side in random bursts.
    always @(negedge clk)
    begin
        if (recv_gap > 0)
        begin
            recv_gap--;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            recv_gap = $urandom_range(0, 10);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Compare each accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            clip_result_t want;
            results_seen++;
            if (clipped_q.size() == 0)
            begin
                $display("ERROR at %0t: result with no request pending", $realtime);
                mismatch_count++;
            end
            else
            begin
                want = clipped_q.pop_front();
                if (want.visible) visible_seen++;
                if (visible !== want.visible)
                    report_mismatch("visible", {31'b0, visible}, {31'b0, want.visible});
                if (out_x_start !== want.xs) report_mismatch("out_x_start", out_x_start, want.xs);
                if (out_y_start !== want.ys) report_mismatch("out_y_start", out_y_start, want.ys);
                if (out_x_finish !== want.xf)
                    report_mismatch("out_x_finish", out_x_finish, want.xf);
                if (out_y_finish !== want.yf)
                    report_mismatch("out_y_finish", out_y_finish, want.yf);
            end
        end
    end

    // End the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
